// ===== rtl/rrps_pkg.sv =====
// ============================================================================
// rrps_pkg: shared definitions for the round-robin process scheduler
// Widths, list depth, request codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
package rrps_pkg;

    // Number of list entries and task numbers the scheduler can track.
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TASK_W    = 4;
    localparam int KIND_W    = 3;
    localparam int SLICE_W   = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(100);
    localparam logic [SLICE_W-1:0] SLICE_MAX   = {SLICE_W{1'b1}};
    localparam logic [TASK_W:0]    TASK_LIMIT  = (TASK_W + 1)'(MAX_TASKS);
    localparam logic [CNT_W-1:0]   LIST_FULL   = CNT_W'(MAX_TASKS);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_BLOCK   = 3'd2,
        KIND_UNBLOCK = 3'd3,
        KIND_TICK    = 3'd4,
        KIND_SCHED   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_needed;
        logic scan_last;
    } dp_stat_t;

endpackage

// ===== rtl/rrps_ctrl.sv =====
// ============================================================================
// rrps_ctrl: request sequencer
// Steps each accepted item through list scan, update and result cycles.
// ============================================================================
module rrps_ctrl
    import rrps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        busy          = 1'b1;
        done          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Requests that do not look a task up go straight to the update.
                if (!stat.scan_needed)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rrps_datapath.sv =====
// ============================================================================
// rrps_datapath: task lists, running task and slice counter
// Holds the ready and blocked lists, scans them one entry a cycle and
// applies each request to the lists in the update cycle.
// ============================================================================
module rrps_datapath
    import rrps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_stat_t            stat,
    input  logic [KIND_W-1:0]   kind,
    input  logic [TASK_W-1:0]   task_id,
    input  logic                cfg_we,
    input  logic [SLICE_W-1:0]  cfg_data,
    output logic                status,
    output logic                running_valid,
    output logic [TASK_W-1:0]   running_id,
    output logic [CNT_W-1:0]    ready_total,
    output logic [CNT_W-1:0]    blocked_total
);

    // Request latched at accept.
    logic [KIND_W-1:0]  kind_reg;
    logic [TASK_W-1:0]  id_reg;

    // Lists and scheduler state.
    logic [TASK_W-1:0]  ready_reg   [MAX_TASKS];
    logic [TASK_W-1:0]  ready_next  [MAX_TASKS];
    logic [TASK_W-1:0]  blocked_reg [MAX_TASKS];
    logic [TASK_W-1:0]  blocked_next[MAX_TASKS];
    logic [CNT_W-1:0]   ready_cnt_reg,   ready_cnt_next;
    logic [CNT_W-1:0]   blocked_cnt_reg, blocked_cnt_next;
    logic               run_flag_reg,  run_flag_next;
    logic [TASK_W-1:0]  run_task_reg,  run_task_next;
    logic [SLICE_W-1:0] slice_cnt_reg, slice_cnt_next;
    logic [SLICE_W-1:0] slice_len_reg;
    logic               status_reg,    status_next;

    // Scan state.
    logic [IDX_W-1:0]   idx_reg;
    logic               found_r_reg, found_b_reg;
    logic [IDX_W-1:0]   pos_r_reg,   pos_b_reg;
    logic               hit_r, hit_b;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   idx_plus;

    // Schedule helper values.
    logic [TASK_W-1:0]  rot     [MAX_TASKS];
    logic               put_back;
    logic [CNT_W-1:0]   rot_cnt;
    logic [SLICE_W-1:0] slice_inc;
    logic               do_sched;
    logic               id_bad;

    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_plus = idx_ext + CNT_W'(1);
    assign hit_r    = (idx_ext < ready_cnt_reg)   && (ready_reg[idx_reg]   == id_reg);
    assign hit_b    = (idx_ext < blocked_cnt_reg) && (blocked_reg[idx_reg] == id_reg);
    assign id_bad   = ({1'b0, id_reg} >= TASK_LIMIT);

    always_comb
    begin
        stat.scan_last = (idx_reg == IDX_W'(MAX_TASKS - 1)) ||
                         ((idx_plus >= ready_cnt_reg) && (idx_plus >= blocked_cnt_reg));
        unique case (kind_reg) inside
            KIND_ADD, KIND_REMOVE, KIND_UNBLOCK: stat.scan_needed = 1'b1;
            default:                             stat.scan_needed = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_len_reg <= SLICE_RESET;
        end
        else if (cfg_we)
        begin
            slice_len_reg <= cfg_data;
        end
    end

    // Request capture and sequential lookup.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            id_reg      <= task_id;
            idx_reg     <= '0;
            found_r_reg <= 1'b0;
            found_b_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (hit_r && !found_r_reg)
            begin
                found_r_reg <= 1'b1;
                pos_r_reg   <= idx_reg;
            end
            if (hit_b && !found_b_reg)
            begin
                found_b_reg <= 1'b1;
                pos_b_reg   <= idx_reg;
            end
            if (!stat.scan_last)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Rotation used by scheduling: the running task goes to the back of the
    // ready list, then the front entry is taken.
    always_comb
    begin
        put_back = run_flag_reg && (ready_cnt_reg < LIST_FULL);
        rot_cnt  = ready_cnt_reg + CNT_W'(put_back);
        for (int j = 0; j < MAX_TASKS; j++)
        begin
            rot[j] = (put_back && (CNT_W'(j) == ready_cnt_reg)) ? run_task_reg : ready_reg[j];
        end
        slice_inc = (slice_cnt_reg == SLICE_MAX) ? slice_cnt_reg
                                                 : slice_cnt_reg + SLICE_W'(1);
    end

    always_comb
    begin
        ready_next       = ready_reg;
        blocked_next     = blocked_reg;
        ready_cnt_next   = ready_cnt_reg;
        blocked_cnt_next = blocked_cnt_reg;
        run_flag_next    = run_flag_reg;
        run_task_next    = run_task_reg;
        slice_cnt_next   = slice_cnt_reg;
        status_next      = 1'b0;
        do_sched         = 1'b0;

        case (kind_reg)
            KIND_ADD:
            begin
                if (id_bad || (run_flag_reg && (run_task_reg == id_reg)) ||
                    found_r_reg || found_b_reg)
                begin
                    status_next = 1'b1;
                end
                else if (ready_cnt_reg < LIST_FULL)
                begin
                    for (int j = 1; j < MAX_TASKS; j++)
                    begin
                        ready_next[j] = ready_reg[j-1];
                    end
                    ready_next[0]  = id_reg;
                    ready_cnt_next = ready_cnt_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (id_bad)
                begin
                    status_next = 1'b1;
                end
                else if (found_r_reg)
                begin
                    for (int j = 0; j < MAX_TASKS - 1; j++)
                    begin
                        if (j >= int'(pos_r_reg))
                        begin
                            ready_next[j] = ready_reg[j+1];
                        end
                    end
                    ready_cnt_next = ready_cnt_reg - CNT_W'(1);
                end
                else if (found_b_reg)
                begin
                    for (int j = 0; j < MAX_TASKS - 1; j++)
                    begin
                        if (j >= int'(pos_b_reg))
                        begin
                            blocked_next[j] = blocked_reg[j+1];
                        end
                    end
                    blocked_cnt_next = blocked_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = 1'b1;
                end
            end
            KIND_BLOCK:
            begin
                if (!run_flag_reg)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    if (blocked_cnt_reg < LIST_FULL)
                    begin
                        for (int j = 1; j < MAX_TASKS; j++)
                        begin
                            blocked_next[j] = blocked_reg[j-1];
                        end
                        blocked_next[0]  = run_task_reg;
                        blocked_cnt_next = blocked_cnt_reg + CNT_W'(1);
                    end
                    run_flag_next  = 1'b0;
                    run_task_next  = '0;
                    slice_cnt_next = '0;
                end
            end
            KIND_UNBLOCK:
            begin
                if (id_bad || !found_b_reg)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    for (int j = 0; j < MAX_TASKS - 1; j++)
                    begin
                        if (j >= int'(pos_b_reg))
                        begin
                            blocked_next[j] = blocked_reg[j+1];
                        end
                    end
                    blocked_cnt_next = blocked_cnt_reg - CNT_W'(1);
                    if (ready_cnt_reg < LIST_FULL)
                    begin
                        for (int j = 1; j < MAX_TASKS; j++)
                        begin
                            ready_next[j] = ready_reg[j-1];
                        end
                        ready_next[0]  = id_reg;
                        ready_cnt_next = ready_cnt_reg + CNT_W'(1);
                    end
                end
            end
            KIND_TICK:
            begin
                if (!run_flag_reg || (slice_inc >= slice_len_reg))
                begin
                    do_sched = 1'b1;
                end
                else
                begin
                    slice_cnt_next = slice_inc;
                end
            end
            KIND_SCHED:
            begin
                do_sched = 1'b1;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase

        if (do_sched)
        begin
            slice_cnt_next = '0;
            if (rot_cnt != '0)
            begin
                run_flag_next = 1'b1;
                run_task_next = rot[0];
                for (int j = 0; j < MAX_TASKS - 1; j++)
                begin
                    ready_next[j] = rot[j+1];
                end
                ready_cnt_next = rot_cnt - CNT_W'(1);
            end
            else
            begin
                run_flag_next = 1'b0;
                run_task_next = '0;
            end
        end
    end

    // List storage has no reset: only entries below the counts are read.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            ready_reg   <= ready_next;
            blocked_reg <= blocked_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_cnt_reg   <= '0;
            blocked_cnt_reg <= '0;
            run_flag_reg    <= 1'b0;
            run_task_reg    <= '0;
            slice_cnt_reg   <= '0;
        end
        else if (cmd.apply)
        begin
            ready_cnt_reg   <= ready_cnt_next;
            blocked_cnt_reg <= blocked_cnt_next;
            run_flag_reg    <= run_flag_next;
            run_task_reg    <= run_task_next;
            slice_cnt_reg   <= slice_cnt_next;
        end
    end

    assign status        = status_reg;
    assign running_valid = run_flag_reg;
    assign running_id    = run_task_reg;
    assign ready_total   = ready_cnt_reg;
    assign blocked_total = blocked_cnt_reg;

endmodule

// ===== rtl/round_robin_process_scheduler_core.sv =====
// ============================================================================
// round_robin_process_scheduler_core: round-robin scheduler with time slice
// Tracks a ready list, a blocked list and one running task, and answers
// every request item with a status and a snapshot of the scheduler state.
// ============================================================================
// An item is accepted on a rising edge with start high and busy low, and
// busy stays high until its result has been shown. The result appears on
// status, running_valid, running_id, ready_total and blocked_total for
// exactly one cycle, marked by done; the receiver cannot stall, so capture
// it in that cycle. Block, tick, schedule-next and unused request codes
// need no lookup and pass from the scan state straight to update and
// result. Add, remove and unblock look the task up by walking the ready
// and blocked lists side by side, one entry per cycle, over the larger
// of the two list lengths (at least one, at most sixteen entries). An
// item holds the block until its result is shown, and the next item can
// be accepted in the cycle after done. The user must write the slice
// length register through cfg_we and cfg_data only while the block is
// idle; the block itself does not enforce this. It resets to 100 ticks.
// ============================================================================
module round_robin_process_scheduler_core
    import rrps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [TASK_W-1:0]   task_id,
    input  logic                cfg_we,
    input  logic [SLICE_W-1:0]  cfg_data,
    output logic                done,
    output logic                status,
    output logic                running_valid,
    output logic [TASK_W-1:0]   running_id,
    output logic [CNT_W-1:0]    ready_total,
    output logic [CNT_W-1:0]    blocked_total
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // The controller sequences each item through lookup, update and result.
    rrps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath owns the lists, the running task and the slice counter.
    // Its result registers change only in the update cycle, so they hold
    // steady while done is high.
    rrps_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .task_id       (task_id),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .status        (status),
        .running_valid (running_valid),
        .running_id    (running_id),
        .ready_total   (ready_total),
        .blocked_total (blocked_total)
    );

endmodule

// ===== rtl/rrps_checker.sv =====
// ============================================================================
// rrps_checker: port-level checks for the scheduler core
// Watches the handshake and the result fields over time.
// ============================================================================
module rrps_checker
    import rrps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                running_valid,
    input logic [TASK_W-1:0]   running_id,
    input logic [CNT_W-1:0]    ready_total,
    input logic [CNT_W-1:0]    blocked_total
);

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    // A result is shown for one cycle only, and the block frees up after it.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done lasted more than one cycle or busy stayed high");

    // A result is only shown while an item is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done seen while idle");

    // With no task running the reported task number reads zero.
    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !running_valid) |-> (running_id == '0))
        else $error("running_id nonzero with no task running");

    // Task numbers are distinct, so all tracked tasks fit in the task space.
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((CNT_W + 1)'(ready_total) + (CNT_W + 1)'(blocked_total) +
                  (CNT_W + 1)'(running_valid) <= (CNT_W + 1)'(MAX_TASKS)))
        else $error("more tasks tracked than task numbers exist");

endmodule

bind round_robin_process_scheduler_core rrps_checker u_rrps_checker (.*);

// ===== test/round_robin_process_scheduler_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// round_robin_process_scheduler_core_tb: self-checking bench for the scheduler
// Sends add, remove, block, unblock, tick, schedule and unused-code requests, predicts each
// response from a private copy of the scheduler lists, and checks every
// response field as it is strobed out, across several slice-length settings.
// ============================================================================
module round_robin_process_scheduler_core_tb;
    import rrps_pkg::*;

    // Request codes the block does not define; they must be rejected.
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    // Extra idle time, after every owed response is in, before the slice
    // register is rewritten.
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] id;
    } sched_req_t;

    typedef struct packed {
        logic              status;
        logic              run_v;
        logic [TASK_W-1:0] run_id;
        logic [CNT_W-1:0]  ready_n;
        logic [CNT_W-1:0]  blocked_n;
    } sched_snapshot_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [KIND_W-1:0]  kind = '0;
    logic [TASK_W-1:0]  task_id = '0;
    logic               cfg_we = 1'b0;
    logic [SLICE_W-1:0] cfg_data = '0;
    logic               busy;
    logic               done;
    logic               status;
    logic               running_valid;
    logic [TASK_W-1:0]  running_id;
    logic [CNT_W-1:0]   ready_total;
    logic [CNT_W-1:0]   blocked_total;

    round_robin_process_scheduler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .task_id       (task_id),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .running_valid (running_valid),
        .running_id    (running_id),
        .ready_total   (ready_total),
        .blocked_total (blocked_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Requests waiting to be offered, and responses the block still owes.
    sched_req_t      pending_reqs[$];
    sched_snapshot_t owed_snapshots[$];

    // Set at the rising edge that accepts an item; the driver reads it at
    // the following falling edge to know the offered item was taken.
    logic took = 1'b0;
    // When set, the driver offers items back to back with no gaps.
    logic quiet = 1'b0;

    // Private copy of the scheduler: lists in order, front at index 0.
    logic [TASK_W-1:0]  ready_order[$];
    logic [TASK_W-1:0]  blocked_order[$];
    logic               task_running = 1'b0;
    logic [TASK_W-1:0]  running_task_id = '0;
    logic [SLICE_W-1:0] ticks_used = '0;
    logic [SLICE_W-1:0] slice_len = SLICE_RESET;

    int mismatches = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    int kind_hits[8];
    int invalid_replies = 0;
    int slice_expiries = 0;
    int deepest_ready = 0;
    int settings_used = 1;

    function automatic int position_of(logic [TASK_W-1:0] ids[$], logic [TASK_W-1:0] id);
        for (int i = 0; i < ids.size(); i++)
        begin
            if (ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Put the running task at the back of the ready list and start the task
    // at the front; with an empty ready list the same task comes right back.
    function automatic void rotate_running();
        if (task_running)
        begin
            if (ready_order.size() < MAX_TASKS)
                ready_order.push_back(running_task_id);
            task_running = 1'b0;
            running_task_id = '0;
        end
        if (ready_order.size() > 0)
        begin
            running_task_id = ready_order.pop_front();
            task_running = 1'b1;
        end
        ticks_used = '0;
    endfunction

    // Apply one request to the private copy and return the response it owes.
    function automatic sched_snapshot_t predict_outcome(sched_req_t req);
        sched_snapshot_t snap;
        logic            invalid;
        logic            id_too_big;
        int              pos;
        invalid = 1'b0;
        id_too_big = ({1'b0, req.id} >= TASK_LIMIT);
        case (req.kind)
            KIND_ADD:
            begin
                if (id_too_big || (task_running && running_task_id == req.id) ||
                    position_of(ready_order, req.id) >= 0 ||
                    position_of(blocked_order, req.id) >= 0)
                    invalid = 1'b1;
                else if (ready_order.size() < MAX_TASKS)
                    ready_order.push_front(req.id);
            end
            KIND_REMOVE:
            begin
                // The running task sits in neither list, so it cannot be removed.
                if (id_too_big)
                    invalid = 1'b1;
                else
                begin
                    pos = position_of(ready_order, req.id);
                    if (pos >= 0)
                        ready_order.delete(pos);
                    else
                    begin
                        pos = position_of(blocked_order, req.id);
                        if (pos >= 0)
                            blocked_order.delete(pos);
                        else
                            invalid = 1'b1;
                    end
                end
            end
            KIND_BLOCK:
            begin
                if (!task_running)
                    invalid = 1'b1;
                else
                begin
                    if (blocked_order.size() < MAX_TASKS)
                        blocked_order.push_front(running_task_id);
                    task_running = 1'b0;
                    running_task_id = '0;
                    ticks_used = '0;
                end
            end
            KIND_UNBLOCK:
            begin
                pos = id_too_big ? -1 : position_of(blocked_order, req.id);
                if (pos < 0)
                    invalid = 1'b1;
                else
                begin
                    blocked_order.delete(pos);
                    if (ready_order.size() < MAX_TASKS)
                        ready_order.push_front(req.id);
                end
            end
            KIND_TICK:
            begin
                // The slice counter saturates; a zero length expires every tick.
                if (task_running)
                begin
                    if (ticks_used != SLICE_MAX)
                        ticks_used = ticks_used + 1'b1;
                    if (ticks_used >= slice_len)
                    begin
                        slice_expiries++;
                        rotate_running();
                    end
                end
                if (!task_running)
                    rotate_running();
            end
            KIND_SCHED:
                rotate_running();
            default:
                invalid = 1'b1;
        endcase
        if (invalid)
            invalid_replies++;
        if (ready_order.size() > deepest_ready)
            deepest_ready = ready_order.size();
        snap.status    = invalid;
        snap.run_v     = task_running;
        snap.run_id    = task_running ? running_task_id : '0;
        snap.ready_n   = CNT_W'(ready_order.size());
        snap.blocked_n = CNT_W'(blocked_order.size());
        return snap;
    endfunction

    // Accepted items and register writes are both seen at the rising edge;
    // the prediction is made right there, while the item is still on the pins.
    always @(posedge clk)
    begin : track_accepts
        sched_req_t req_now;
        if (rst_n)
        begin
            if (cfg_we)
                slice_len = cfg_data;
            took <= start && !busy;
            if (start && !busy)
            begin
                req_now = {kind, task_id};
                kind_hits[kind]++;
                owed_snapshots.push_back(predict_outcome(req_now));
            end
        end
    end

    // The driver works on the falling edge. An item stays offered until it is
    // taken; start is computed once per edge so it never glitches between
    // back-to-back items.
    always @(negedge clk)
    begin : drive_requests
        logic       offer;
        sched_req_t next_req;
        if (rst_n)
        begin
            offer = start;
            if (offer && took)
                offer = 1'b0;
            if (!offer && pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 23))
            begin
                next_req = pending_reqs.pop_front();
                kind    <= next_req.kind;
                task_id <= next_req.id;
                offer = 1'b1;
            end
            start <= offer;
        end
    end

    // The monitor captures each strobed response in its single valid cycle and
    // checks it against the oldest owed response. It also runs the watchdog,
    // which counts cycles where neither side of the block makes progress.
    always @(posedge clk)
    begin : check_responses
        sched_snapshot_t got;
        sched_snapshot_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = {status, running_valid, running_id, ready_total, blocked_total};
                if (owed_snapshots.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] response with none owed: status=%0b run=%0b id=%0d ready=%0d blocked=%0d",
                                 $realtime, got.status, got.run_v, got.run_id,
                                 got.ready_n, got.blocked_n);
                end
                else
                begin
                    want = owed_snapshots.pop_front();
                    results_checked++;
                    if (got.status != want.status || got.run_v != want.run_v ||
                        got.run_id != want.run_id || got.ready_n != want.ready_n ||
                        got.blocked_n != want.blocked_n)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("[%0t] response %0d mismatch", $realtime, results_checked);
                            $display("    expected status=%0b run=%0b id=%0d ready=%0d blocked=%0d",
                                     want.status, want.run_v, want.run_id,
                                     want.ready_n, want.blocked_n);
                            $display("    actual   status=%0b run=%0b id=%0d ready=%0d blocked=%0d",
                                     got.status, got.run_v, got.run_id,
                                     got.ready_n, got.blocked_n);
                        end
                    end
                end
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles, %0d responses still owed",
                         $realtime, quiet_cycles, owed_snapshots.size());
                $display("round_robin_process_scheduler_core_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_req(logic [KIND_W-1:0] k, logic [TASK_W-1:0] id);
        sched_req_t req;
        req.kind = k;
        req.id   = id;
        pending_reqs.push_back(req);
    endtask

    // Random traffic is mostly meaningful scheduling: adds and ticks dominate
    // so the lists fill up and slices expire, with a small share of unused
    // request codes mixed in as noise.
    task automatic queue_random(int count);
        int                pick;
        logic [TASK_W-1:0] id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            id   = TASK_W'($urandom_range(MAX_TASKS - 1));
            if (pick < 26)
                queue_req(KIND_ADD, id);
            else if (pick < 36)
                queue_req(KIND_REMOVE, id);
            else if (pick < 45)
                queue_req(KIND_BLOCK, id);
            else if (pick < 57)
                queue_req(KIND_UNBLOCK, id);
            else if (pick < 86)
                queue_req(KIND_TICK, id);
            else if (pick < 96)
                queue_req(KIND_SCHED, id);
            else
                queue_req($urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B, id);
        end
    endtask

    // Hold off until every offered item has been answered, then let the
    // block settle before anything else touches it.
    task automatic await_quiet();
        while (pending_reqs.size() != 0 || start || owed_snapshots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slice(logic [SLICE_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : run_phases
        int slice_choices[6];
        int phase_lengths[6];
        slice_choices = '{1, 0, 3, 65535, 2, 7};
        phase_lengths = '{90, 70, 120, 80, 100, 160};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk through every request and every rejection path,
        // using the reset slice length.
        queue_req(KIND_ADD, 4'd0);
        queue_req(KIND_ADD, 4'd15);
        queue_req(KIND_ADD, 4'd15);        // already ready
        queue_req(KIND_TICK, 4'd0);        // nothing running: picks task 15
        queue_req(KIND_ADD, 4'd15);        // already running
        queue_req(KIND_BLOCK, 4'd0);
        queue_req(KIND_BLOCK, 4'd0);       // nothing running to block
        queue_req(KIND_ADD, 4'd15);        // already blocked
        queue_req(KIND_UNBLOCK, 4'd0);     // not blocked
        queue_req(KIND_UNBLOCK, 4'd15);
        queue_req(KIND_SCHED, 4'd0);
        queue_req(KIND_REMOVE, 4'd15);     // running tasks cannot be removed
        queue_req(KIND_REMOVE, 4'd0);
        queue_req(KIND_SCHED, 4'd0);       // empty ready list: same task again
        queue_req(KIND_BLOCK, 4'd0);
        queue_req(KIND_SCHED, 4'd0);       // nothing left to run
        queue_req(KIND_REMOVE, 4'd15);     // removed from the blocked list
        queue_req(KIND_REMOVE, 4'd7);      // unknown task
        queue_req(KIND_SPARE_A, 4'd10);
        queue_req(KIND_SPARE_B, 4'd5);
        queue_req(KIND_TICK, 4'd0);        // idle tick with nothing ready
        queue_req(KIND_ADD, 4'd5);
        queue_req(KIND_ADD, 4'd9);
        queue_req(KIND_TICK, 4'd0);
        queue_req(KIND_TICK, 4'd0);

        // Each phase drains completely before the slice length changes,
        // which also forces the sender to sit idle until all answers are in.
        for (int p = 0; p < 6; p++)
        begin
            await_quiet();
            write_slice(SLICE_W'(slice_choices[p]));
            quiet = (slice_choices[p] == 3);
            queue_random(phase_lengths[p]);
        end

        await_quiet();

        $display("Checked %0d responses over %0d slice settings: %0d add, %0d remove, %0d block,",
                 results_checked, settings_used, kind_hits[KIND_ADD], kind_hits[KIND_REMOVE],
                 kind_hits[KIND_BLOCK]);
        $display("%0d unblock, %0d tick, %0d schedule, %0d unused; %0d rejected, %0d slice expiries, ready list up to %0d.",
                 kind_hits[KIND_UNBLOCK], kind_hits[KIND_TICK], kind_hits[KIND_SCHED],
                 kind_hits[KIND_SPARE_A] + kind_hits[KIND_SPARE_B], invalid_replies,
                 slice_expiries, deepest_ready);
        if (mismatches == 0)
            $display("round_robin_process_scheduler_core_tb: PASS");
        else
            $display("round_robin_process_scheduler_core_tb: FAIL");
        $finish;
    end

endmodule
